@@ hw/rtl/bco_pkg.sv @@
// Box-count occupancy package: FSM state type, request codes and register indexes.
// No dependencies; imported by the core.
package bco_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_YSTEP,
    S_XSTEP,
    S_RD,
    S_CHK,
    S_DONE
  } bco_state_t;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_COUNT = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

endpackage

@@ hw/rtl/bco_bitmap.sv @@
// Pixel bitmap: one bit per pixel, one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module bco_bitmap #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/box_count_occupancy_core.sv @@
// Box-count occupancy core: bitmap load and box-count sequencer.
// Depends on bco_pkg and bco_bitmap.
//
// Pixel loads (req_type 0) never raise busy, so they can be issued every cycle while no
// count is running. A count (req_type 1) raises busy until its result strobe on done.
// A count runs the box-size divider (one quotient bit per cycle); then the box edge
// steppers, one subtract or one decision per cycle, down the rows and across each row of
// boxes that lies inside the raster; then the pixel reads from the bitmap, which has a
// single read port, each read issued in S_RD and checked in S_CHK, a box being read only
// up to its first filled pixel; and the strobe in S_DONE. A count whose box size is below
// two strobes done in the cycle right after its transfer. done is high for one cycle and
// the results cannot be held off.
`default_nettype none
module box_count_occupancy_core
  import bco_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type,
  input  wire logic [8:0]  pixel_x,
  input  wire logic [8:0]  pixel_y,
  input  wire logic        pixel_filled,
  input  wire logic [9:0]  grid_count,
  output logic             done,
  output logic [16:0]      filled_boxes,
  output logic [17:0]      box_size_q8,
  output logic             size_too_small,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [9:0]  cfg_data
);

  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW    = $clog2(MAXD + 1);
  localparam int RW    = DW + 2;
  localparam int QW    = DW + 9;
  localparam int CW    = $clog2(QW + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  bco_state_t state, state_next;

  logic [9:0]    raster_width, raster_height;
  logic [DW-1:0] w_r, h_r, m_r, n_r;
  logic [DW-1:0] j, i, y0, yq, x0, xq, y1c, x1c, px, py;
  logic [RW-1:0] yrem, xrem;
  logic [QW-1:0] dnum, dq;
  logic [DW:0]   drem;
  logic [CW-1:0] dcnt;
  logic [16:0]   count;
  logic [17:0]   size_r;
  logic          small_r;
  logic          rd_data;

  // start-time dimension clamps
  logic [12:0] w_c, h_c, m_c;
  logic [15:0] two_n_full;
  logic        too_small;
  always_comb begin
    w_c = {3'd0, raster_width};
    h_c = {3'd0, raster_height};
    if (w_c == 13'd0) w_c = 13'd1;
    if (w_c > 13'(MAX_WIDTH)) w_c = 13'(MAX_WIDTH);
    if (h_c == 13'd0) h_c = 13'd1;
    if (h_c > 13'(MAX_HEIGHT)) h_c = 13'(MAX_HEIGHT);
    m_c = (w_c > h_c) ? w_c : h_c;
    two_n_full = {5'd0, grid_count, 1'b0};
    too_small = (grid_count == 10'd0) || ({3'd0, m_c} < two_n_full);
  end

  logic [DW:0]   two_n, two_m;
  logic          ystep_sub, xstep_sub, row_skip, box_skip, last_row, last_box;
  logic          px_end, py_end, hit_end, do_box_next, do_row_next;
  logic [DW-1:0] y1cand, x1cand;
  logic [DW+1:0] dtrial;
  always_comb begin
    two_n     = {n_r, 1'b0};
    two_m     = {m_r, 1'b0};
    ystep_sub = yrem >= RW'(two_n);
    xstep_sub = xrem >= RW'(two_n);
    y1cand    = (yq >= h_r) ? h_r - DW'(1) : yq;
    x1cand    = (xq >= w_r) ? w_r - DW'(1) : xq;
    row_skip  = y0 > y1cand;
    box_skip  = x0 > x1cand;
    last_row  = j == n_r - DW'(1);
    last_box  = i == n_r - DW'(1);
    px_end    = px == x1c;
    py_end    = py == y1c;
    hit_end   = rd_data || (px_end && py_end);
    do_box_next = (state == S_XSTEP && !xstep_sub && box_skip) || (state == S_CHK && hit_end);
    do_row_next = (state == S_YSTEP && !ystep_sub && row_skip) || (do_box_next && last_box);
    dtrial    = {drem, dnum[QW-1]};
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start && req_type == REQ_COUNT) state_next = too_small ? S_DONE : S_DIV;
      S_DIV:   if (dcnt == '0) state_next = S_YSTEP;
      S_YSTEP: begin
        if (!ystep_sub) begin
          if (row_skip) state_next = last_row ? S_DONE : S_YSTEP;
          else state_next = S_XSTEP;
        end
      end
      S_XSTEP: begin
        if (!xstep_sub) begin
          if (box_skip) state_next = last_box ? (last_row ? S_DONE : S_YSTEP) : S_XSTEP;
          else state_next = S_RD;
        end
      end
      S_RD:    state_next = S_CHK;
      S_CHK: begin
        if (hit_end) state_next = last_box ? (last_row ? S_DONE : S_YSTEP) : S_XSTEP;
        else state_next = S_RD;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE:  busy = 1'b0;
      S_DONE:  done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  assign filled_boxes   = count;
  assign box_size_q8    = size_r;
  assign size_too_small = small_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      raster_width  <= 10'd512;
      raster_height <= 10'd512;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) raster_width <= cfg_data;
        else raster_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start && req_type == REQ_COUNT) begin
          w_r     <= DW'(w_c);
          h_r     <= DW'(h_c);
          m_r     <= DW'(m_c);
          n_r     <= DW'(grid_count);
          count   <= '0;
          small_r <= too_small;
          size_r  <= '0;
          drem    <= '0;
          dq      <= '0;
          dcnt    <= CW'(QW - 1);
          dnum    <= QW'({m_c, 8'd0}) + QW'(grid_count[9:1]);
          j       <= '0;
          y0      <= '0;
          yq      <= '0;
          yrem    <= RW'(grid_count) + RW'({m_c, 1'b0});
        end
      end
      S_DIV: begin
        dnum <= {dnum[QW-2:0], 1'b0};
        if (dtrial >= (DW+2)'(n_r)) begin
          drem <= (DW+1)'(dtrial - (DW+2)'(n_r));
          dq   <= {dq[QW-2:0], 1'b1};
        end else begin
          drem <= dtrial[DW:0];
          dq   <= {dq[QW-2:0], 1'b0};
        end
        if (dcnt == '0) begin
          size_r <= 18'({dq[QW-2:0], (dtrial >= (DW+2)'(n_r))});
        end
        dcnt <= dcnt - CW'(1);
      end
      S_YSTEP: begin
        if (ystep_sub) begin
          yrem <= yrem - RW'(two_n);
          yq   <= yq + DW'(1);
        end else if (!row_skip) begin
          y1c  <= y1cand;
          i    <= '0;
          x0   <= '0;
          xq   <= '0;
          xrem <= RW'(n_r) + RW'(two_m);
        end
      end
      S_XSTEP: begin
        if (xstep_sub) begin
          xrem <= xrem - RW'(two_n);
          xq   <= xq + DW'(1);
        end else if (!box_skip) begin
          x1c <= x1cand;
          px  <= x0;
          py  <= y0;
        end
      end
      S_CHK: begin
        if (rd_data) begin
          count <= count + 17'd1;
        end else if (px_end) begin
          px <= x0;
          py <= py + DW'(1);
        end else begin
          px <= px + DW'(1);
        end
      end
      default: ;
    endcase
    if (do_box_next && !last_box) begin
      i    <= i + DW'(1);
      x0   <= xq;
      xrem <= xrem + RW'(two_m);
    end
    if (do_row_next && !last_row) begin
      j    <= j + DW'(1);
      y0   <= yq;
      yrem <= yrem + RW'(two_m);
    end
  end

  logic          load_we;
  logic [AW-1:0] waddr, raddr;
  always_comb begin
    load_we = start && !busy && req_type == REQ_LOAD
              && ({4'd0, pixel_x} < 13'(MAX_WIDTH)) && ({4'd0, pixel_y} < 13'(MAX_HEIGHT));
    waddr = AW'(int'(pixel_y) * MAX_WIDTH + int'(pixel_x));
    raddr = AW'(int'(py) * MAX_WIDTH + int'(px));
  end

  bco_bitmap #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_bitmap (
    .clk  (clk),
    .we   (load_we),
    .waddr(waddr),
    .wdata(pixel_filled),
    .re   (state == S_RD),
    .raddr(raddr),
    .rdata(rd_data)
  );

endmodule
`default_nettype wire

@@ hw/rtl/bco_checker.sv @@
// Port-level checker for the box-count occupancy core, with its bind.
// Depends on bco_pkg and the core's ports.
`default_nettype none
module bco_checker
  import bco_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        req_type,
  input wire logic        done,
  input wire logic [16:0] filled_boxes,
  input wire logic [17:0] box_size_q8,
  input wire logic        size_too_small
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a count");

  a_count_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_COUNT) |=> busy)
    else $error("count transfer did not raise busy");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_LOAD) |=> !busy)
    else $error("pixel load raised busy");

  a_small_zero: assert property (@(posedge clk) disable iff (rst)
    (done && size_too_small) |-> (filled_boxes == 17'd0 && box_size_q8 == 18'd0))
    else $error("small-size result not cleared");

  a_done_release: assert property (@(posedge clk) disable iff (rst) done |=> !busy && !done)
    else $error("busy held after result");

endmodule

bind box_count_occupancy_core bco_checker u_bco_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .req_type      (req_type),
  .done          (done),
  .filled_boxes  (filled_boxes),
  .box_size_q8   (box_size_q8),
  .size_too_small(size_too_small)
);
`default_nettype wire

@@ bench/tb.sv @@
// Testbench for box_count_occupancy_core: loads raster pixels, runs box counts
// and checks every count result against an in-bench occupancy predictor.
// Depends on bco_pkg and the core RTL.
`default_nettype none
module tb
  import bco_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [16:0] filled;
    logic [17:0] size_q8;
    logic        too_small;
  } count_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = REQ_LOAD;
  logic [8:0]  pixel_x = '0;
  logic [8:0]  pixel_y = '0;
  logic        pixel_filled = 1'b0;
  logic [9:0]  grid_count = '0;
  logic        done;
  logic [16:0] filled_boxes;
  logic [17:0] box_size_q8;
  logic        size_too_small;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_WIDTH;
  logic [9:0]  cfg_data = '0;

  box_count_occupancy_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .pixel_filled(pixel_filled), .grid_count(grid_count),
    .done(done), .filled_boxes(filled_boxes), .box_size_q8(box_size_q8),
    .size_too_small(size_too_small),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bit            raster [0:511][0:511];
  bit            written [0:511][0:511];
  logic [9:0]    reg_w = 10'd512;
  logic [9:0]    reg_h = 10'd512;
  count_result_t pending_counts[$];
  int            errors = 0;
  bit            gaps_on = 1'b1;

  function automatic int eff_dim(input logic [9:0] v);
    if (v == 0) return 1;
    if (v > 512) return 512;
    return int'(v);
  endfunction

  function automatic longint box_edge_at(input longint k, m, n);
    return (2 * k * m + n) / (2 * n);
  endfunction

  function automatic count_result_t occupancy(input logic [9:0] n_in);
    count_result_t r;
    longint w, h, m, n, x0, x1, y0, y1, cnt;
    bit hit;
    w = eff_dim(reg_w);
    h = eff_dim(reg_h);
    m = (w > h) ? w : h;
    n = n_in;
    if (n == 0 || m < 2 * n) begin
      r.filled = '0; r.size_q8 = '0; r.too_small = 1'b1;
      return r;
    end
    cnt = 0;
    for (longint j = 0; j < n; j++) begin
      y0 = box_edge_at(j, m, n);
      y1 = box_edge_at(j + 1, m, n);
      if (y1 >= h) y1 = h - 1;
      if (y0 > y1) continue;
      for (longint i = 0; i < n; i++) begin
        x0 = box_edge_at(i, m, n);
        x1 = box_edge_at(i + 1, m, n);
        if (x1 >= w) x1 = w - 1;
        if (x0 > x1) continue;
        hit = 1'b0;
        for (longint y = y0; y <= y1 && !hit; y++)
          for (longint x = x0; x <= x1 && !hit; x++)
            if (raster[y][x]) hit = 1'b1;
        if (hit) cnt++;
      end
    end
    r.filled = cnt[16:0];
    r.size_q8 = 18'((m * 256 + n / 2) / n);
    r.too_small = 1'b0;
    return r;
  endfunction

  task automatic send_item(input logic rq, input logic [8:0] x, input logic [8:0] y,
                           input logic f, input logic [9:0] n);
    while (gaps_on && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req_type <= rq;
    pixel_x <= x;
    pixel_y <= y;
    pixel_filled <= f;
    grid_count <= n;
    do @(posedge clk); while (busy);
    if (rq == REQ_LOAD) begin
      raster[y][x] = f;
      written[y][x] = 1'b1;
    end else begin
      pending_counts.push_back(occupancy(n));
    end
  endtask

  task automatic load_pixel(input int x, input int y, input int density);
    send_item(REQ_LOAD, 9'(x), 9'(y), $urandom_range(0, 99) < density, 10'($urandom));
  endtask

  task automatic request_count(input logic [9:0] n);
    send_item(REQ_COUNT, 9'($urandom), 9'($urandom), 1'($urandom), n);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [9:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) reg_w = val; else reg_h = val;
  endtask

  // every pixel a count can touch must be written first
  task automatic fill_raster(input int density);
    int w, h;
    w = eff_dim(reg_w);
    h = eff_dim(reg_h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        if (!written[y][x]) load_pixel(x, y, density);
  endtask

  task automatic test_directed;
    write_reg(REG_WIDTH, 10'd16);
    write_reg(REG_HEIGHT, 10'd12);
    fill_raster(10);
    send_item(REQ_LOAD, 9'd511, 9'd511, 1'b1, 10'h3FF);
    send_item(REQ_LOAD, 9'd0, 9'd0, 1'b1, 10'h000);
    request_count(10'd1);
    request_count(10'd2);
    request_count(10'd3);
    request_count(10'd6);
    request_count(10'd8);
    request_count(10'd9);
    request_count(10'd0);
    request_count(10'd1023);
    request_count(10'd512);
    send_item(REQ_LOAD, 9'd15, 9'd11, 1'b1, 10'd5);
    send_item(REQ_LOAD, 9'd0, 9'd0, 1'b0, 10'd5);
    request_count(10'd5);
  endtask

  task automatic test_extreme_shapes;
    write_reg(REG_WIDTH, 10'd1023);
    write_reg(REG_HEIGHT, 10'd1);
    fill_raster(3);
    request_count(10'd1);
    request_count(10'd7);
    request_count(10'd256);
    request_count(10'd257);
    write_reg(REG_WIDTH, 10'd1);
    write_reg(REG_HEIGHT, 10'd512);
    fill_raster(3);
    request_count(10'd2);
    request_count(10'd100);
    write_reg(REG_WIDTH, 10'd0);
    write_reg(REG_HEIGHT, 10'd0);
    request_count(10'd1);
    write_reg(REG_HEIGHT, 10'd3);
    request_count(10'd1);
  endtask

  task automatic test_random(input int items, input bit no_gaps);
    int w, h, m, density;
    write_reg(REG_WIDTH, 10'($urandom_range(1, 24)));
    write_reg(REG_HEIGHT, 10'($urandom_range(1, 24)));
    gaps_on = !no_gaps;
    w = eff_dim(reg_w);
    h = eff_dim(reg_h);
    m = (w > h) ? w : h;
    density = $urandom_range(2, 40);
    fill_raster(density);
    for (int k = 0; k < items; k++) begin
      if (k == items / 2) drain();
      case ($urandom_range(0, 19))
        0, 1: send_item(REQ_LOAD, 9'($urandom), 9'($urandom), 1'($urandom), 10'($urandom));
        2, 3, 4: request_count(10'($urandom_range(1, (m / 2 > 1) ? m / 2 : 1)));
        5: request_count(10'($urandom));
        default: load_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1), density);
      endcase
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_counts.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        count_result_t e;
        e = pending_counts.pop_front();
        if (filled_boxes !== e.filled) begin
          $error("filled_boxes exp %0d got %0d", e.filled, filled_boxes);
          errors++;
        end
        if (box_size_q8 !== e.size_q8) begin
          $error("box_size_q8 exp %0d got %0d", e.size_q8, box_size_q8);
          errors++;
        end
        if (size_too_small !== e.too_small) begin
          $error("size_too_small exp %0d got %0d", e.too_small, size_too_small);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_shapes();
    test_random(110, 1'b0);
    test_random(110, 1'b1);
    test_random(110, 1'b0);
    test_random(110, 1'b0);
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_counts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
